/* src/rau_pkg.sv */
// rau_pkg: word width, command and status types and helper functions
// shared by the rational arithmetic unit controller and datapath.
// No dependencies.
package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam int W         = WORD_BITS;
  localparam int CNT_W     = $clog2(WORD_BITS) + 1;
  localparam int K_W       = $clog2(WORD_BITS);

  typedef logic [W-1:0] word_t;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_EQ  = 3'd4;

  localparam logic [1:0] MSTEP_0 = 2'd0;
  localparam logic [1:0] MSTEP_1 = 2'd1;
  localparam logic [1:0] MSTEP_2 = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_ADD, S_COPYA, S_GINIT, S_GSTEP,
    S_DSTEPN, S_DINITD, S_DSTEPD, S_AFTER, S_FIN
  } ctl_state_t;

  typedef enum logic [3:0] {
    C_NOP, C_LOAD, C_MUL, C_ADD, C_COPY_A, C_SWAP_B, C_GCD_INIT, C_GCD_STEP,
    C_DIV_INIT, C_DIV_STEP, C_DIV_STORE, C_FINISH
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t  code;
    logic [2:0] op;
    logic [1:0] mul_step;
    logic       div_den;  // 1: divider works on the denominator
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;      // numerator or denominator zero, no reduction
    logic gcd_done;
    logic div_done;
  } dp_stat_t;

  function automatic word_t mag(input word_t v);
    return v[W-1] ? word_t'(-v) : v;
  endfunction

  function automatic word_t wrap_in(input logic [31:0] f);
    logic signed [63:0] t;
    t = 64'(signed'(f));
    return t[W-1:0];
  endfunction

  function automatic logic [31:0] to_field(input word_t v);
    logic signed [63:0] t;
    t = 64'(signed'(v));
    return t[31:0];
  endfunction

endpackage

/* src/rational_arith_unit.sv */
// rational_arith_unit: top level of the fraction add/sub/mul/div/compare
// unit. Instantiates rau_ctrl and rau_dp; depends on rau_pkg.
//
// One transaction at a time. Add and subtract form three products and a
// sum through one shared WORD_BITS multiplier, multiply and divide two
// products. Reduction then runs a binary gcd, one shift or subtract a
// cycle, and two restoring divisions, one for the numerator and one for
// the denominator; compare reduces both operands. Reduction is skipped
// when numerator or denominator is zero. A finished result sits in the
// output register while the next transaction is accepted.
module rational_arith_unit import rau_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_a_num,
  input  logic [31:0] in_a_den,
  input  logic [31:0] in_b_num,
  input  logic [31:0] in_b_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_res_num,
  output logic [31:0] out_res_den,
  output logic        out_is_equal,
  output logic        out_overflow,
  output logic        out_zero_den
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequence commands: load, multiply or copy, reduce, hold result.
  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Hold operands and do the arithmetic.
  rau_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .stat     (stat),
    .in_a_num (in_a_num),
    .in_a_den (in_a_den),
    .in_b_num (in_b_num),
    .in_b_den (in_b_den),
    .res_num  (out_res_num),
    .res_den  (out_res_den),
    .res_eq   (out_is_equal),
    .res_ovf  (out_overflow),
    .res_zd   (out_zero_den)
  );

endmodule

/* src/rau_ctrl.sv */
// rau_ctrl: sequencing state machine of the rational arithmetic unit.
// Depends on rau_pkg.
module rau_ctrl import rau_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_op,
  output logic       out_valid,
  input  logic       out_ready,
  output ctrl_cmd_t  cmd,
  input  dp_stat_t   stat
);

  ctl_state_t state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic       phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_ADD;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.code      = C_NOP;
    cmd.op        = op_r;
    cmd.mul_step  = MSTEP_0;
    cmd.div_den   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = in_op;
        if (in_valid) begin
          cmd.code  = C_LOAD;
          op_nxt    = in_op;
          phase_nxt = 1'b0;
          if (in_op <= OP_DIV)     state_nxt = S_MUL0;
          else if (in_op == OP_EQ) state_nxt = S_COPYA;
          else                     state_nxt = S_FIN;
        end
      end
      S_MUL0: begin
        cmd.code = C_MUL; cmd.mul_step = MSTEP_0; state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.code = C_MUL; cmd.mul_step = MSTEP_1;
        state_nxt = (op_r <= OP_SUB) ? S_MUL2 : S_GINIT;
      end
      S_MUL2: begin
        cmd.code = C_MUL; cmd.mul_step = MSTEP_2; state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.code = C_ADD; state_nxt = S_GINIT;
      end
      S_COPYA: begin
        cmd.code = C_COPY_A; state_nxt = S_GINIT;
      end
      S_GINIT: begin
        if (stat.skip) begin
          state_nxt = S_AFTER;
        end else begin
          cmd.code = C_GCD_INIT; state_nxt = S_GSTEP;
        end
      end
      S_GSTEP: begin
        if (stat.gcd_done) begin
          cmd.code = C_DIV_INIT; state_nxt = S_DSTEPN;
        end else begin
          cmd.code = C_GCD_STEP;
        end
      end
      S_DSTEPN: begin
        if (stat.div_done) begin
          cmd.code = C_DIV_STORE; state_nxt = S_DINITD;
        end else begin
          cmd.code = C_DIV_STEP;
        end
      end
      S_DINITD: begin
        cmd.code = C_DIV_INIT; cmd.div_den = 1'b1; state_nxt = S_DSTEPD;
      end
      S_DSTEPD: begin
        cmd.div_den = 1'b1;
        if (stat.div_done) begin
          cmd.code = C_DIV_STORE; state_nxt = S_AFTER;
        end else begin
          cmd.code = C_DIV_STEP;
        end
      end
      S_AFTER: begin
        if (op_r == OP_EQ && !phase_r) begin
          cmd.code = C_SWAP_B; phase_nxt = 1'b1; state_nxt = S_GINIT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.code      = C_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* src/rau_dp.sv */
// rau_dp: operand registers, shared multiplier, binary gcd and serial
// divider of the rational arithmetic unit. Depends on rau_pkg.
module rau_dp import rau_pkg::*; (
  input  logic        clk,
  input  ctrl_cmd_t   cmd,
  output dp_stat_t    stat,
  input  logic [31:0] in_a_num,
  input  logic [31:0] in_a_den,
  input  logic [31:0] in_b_num,
  input  logic [31:0] in_b_den,
  output logic [31:0] res_num,
  output logic [31:0] res_den,
  output logic        res_eq,
  output logic        res_ovf,
  output logic        res_zd
);

  word_t an_r, ad_r, bn_r, bd_r, p_r, q_r, rn_r, rd_r;
  word_t u_r, v_r, g_r, dq_r, rem_r;
  logic [K_W-1:0]   k_r;
  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;
  logic [31:0]      rnum_r, rden_r;
  logic             req_r, rovf_r, rzd_r;

  logic signed [W-1:0]   ma, mb;
  logic signed [2*W-1:0] prod;
  logic                  prod_ovf;
  word_t                 sum, div_q;
  logic                  sub, sy, sum_ovf, ge, tgt_neg;
  logic [W:0]            sh, shd;

  always_comb begin
    ma = an_r;
    mb = bd_r;
    case (cmd.mul_step)
      MSTEP_0: begin
        ma = an_r; mb = (cmd.op == OP_MUL) ? bn_r : bd_r;
      end
      MSTEP_1: begin
        if (cmd.op <= OP_SUB)      begin ma = bn_r; mb = ad_r; end
        else if (cmd.op == OP_MUL) begin ma = ad_r; mb = bd_r; end
        else                       begin ma = ad_r; mb = bn_r; end
      end
      default: begin
        ma = ad_r; mb = bd_r;
      end
    endcase
    prod     = ma * mb;
    prod_ovf = |prod[2*W-1:W-1] && !(&prod[2*W-1:W-1]);
    sub      = (cmd.op == OP_SUB);
    sum      = sub ? word_t'(p_r - q_r) : word_t'(p_r + q_r);
    sy       = q_r[W-1] ^ sub;
    sum_ovf  = (p_r[W-1] == sy) && (sum[W-1] != p_r[W-1]);
    sh       = {rem_r, dq_r[W-1]};
    ge       = sh >= {1'b0, g_r};
    shd      = sh - {1'b0, g_r};
    tgt_neg  = cmd.div_den ? rd_r[W-1] : rn_r[W-1];
    div_q    = tgt_neg ? word_t'(-dq_r) : dq_r;
  end

  assign stat.skip     = (rn_r == '0) || (rd_r == '0);
  assign stat.gcd_done = (u_r == '0) || (v_r == '0);
  assign stat.div_done = (cnt_r == CNT_W'(WORD_BITS));

  always_ff @(posedge clk) begin
    case (cmd.code)
      C_LOAD: begin
        an_r  <= wrap_in(in_a_num);
        ad_r  <= wrap_in(in_a_den);
        bn_r  <= wrap_in(in_b_num);
        bd_r  <= wrap_in(in_b_den);
        ovf_r <= 1'b0;
      end
      C_MUL: begin
        ovf_r <= ovf_r | prod_ovf;
        case (cmd.mul_step)
          MSTEP_0: if (cmd.op <= OP_SUB) p_r <= prod[W-1:0]; else rn_r <= prod[W-1:0];
          MSTEP_1: if (cmd.op <= OP_SUB) q_r <= prod[W-1:0]; else rd_r <= prod[W-1:0];
          default: rd_r <= prod[W-1:0];
        endcase
      end
      C_ADD: begin
        rn_r  <= sum;
        ovf_r <= ovf_r | sum_ovf;
      end
      C_COPY_A: begin
        rn_r <= an_r;
        rd_r <= ad_r;
      end
      C_SWAP_B: begin
        p_r  <= rn_r;
        q_r  <= rd_r;
        rn_r <= bn_r;
        rd_r <= bd_r;
      end
      C_GCD_INIT: begin
        u_r <= mag(rn_r);
        v_r <= mag(rd_r);
        k_r <= '0;
      end
      C_GCD_STEP: begin
        if (!u_r[0] && !v_r[0]) begin
          u_r <= u_r >> 1;
          v_r <= v_r >> 1;
          k_r <= K_W'(k_r + 1'b1);
        end else if (!u_r[0]) begin
          u_r <= u_r >> 1;
        end else if (!v_r[0]) begin
          v_r <= v_r >> 1;
        end else if (u_r >= v_r) begin
          u_r <= word_t'(u_r - v_r) >> 1;
        end else begin
          v_r <= word_t'(v_r - u_r) >> 1;
        end
      end
      C_DIV_INIT: begin
        if (!cmd.div_den) g_r <= (u_r | v_r) << k_r;
        dq_r  <= cmd.div_den ? mag(rd_r) : mag(rn_r);
        rem_r <= '0;
        cnt_r <= '0;
      end
      C_DIV_STEP: begin
        rem_r <= ge ? shd[W-1:0] : sh[W-1:0];
        dq_r  <= {dq_r[W-2:0], ge};
        cnt_r <= CNT_W'(cnt_r + 1'b1);
      end
      C_DIV_STORE: begin
        if (cmd.div_den) rd_r <= div_q; else rn_r <= div_q;
      end
      C_FINISH: begin
        if (cmd.op <= OP_DIV) begin
          rnum_r <= to_field(rn_r);
          rden_r <= to_field(rd_r);
          req_r  <= 1'b0;
          rovf_r <= ovf_r;
          rzd_r  <= (rd_r == '0);
        end else begin
          rnum_r <= 32'd0;
          rden_r <= 32'd1;
          req_r  <= (cmd.op == OP_EQ) && (p_r == rn_r) && (q_r == rd_r);
          rovf_r <= 1'b0;
          rzd_r  <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign res_num = rnum_r;
  assign res_den = rden_r;
  assign res_eq  = req_r;
  assign res_ovf = rovf_r;
  assign res_zd  = rzd_r;

endmodule

/* src/rau_checker.sv */
// rau_checker: port-level assertions for rational_arith_unit, bound to
// the top level. Depends on nothing but the top-level ports.
module rau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_res_num,
  input logic [31:0] out_res_den,
  input logic        out_is_equal,
  input logic        out_overflow,
  input logic        out_zero_den
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_num) && $stable(out_res_den))
    else $error("result changed while stalled");

  a_eq_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_equal |-> out_res_num == 32'd0 && out_res_den == 32'd1
                                  && !out_overflow && !out_zero_den)
    else $error("compare result fields wrong");

  a_zd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_den |-> out_res_den == 32'd0)
    else $error("zero_den without zero denominator");

  a_zd_rev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res_den == 32'd0 |-> out_zero_den)
    else $error("zero denominator not flagged");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_res_num  (out_res_num),
  .out_res_den  (out_res_den),
  .out_is_equal (out_is_equal),
  .out_overflow (out_overflow),
  .out_zero_den (out_zero_den)
);
